FILE: rtl/rvex_pkg.sv
// Shared definitions for the RV64I integer execute pipeline.
// Opcode groups, operation kinds and data widths; no dependencies.
package rvex_pkg;

    // Field widths on the ports
    localparam int DATA_W   = 64;
    localparam int INSN_W   = 32;
    localparam int REG_IDX_W = 5;
    localparam int XLEN_DEF = 64;

    // Packed word widths (whole bytes)
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 144;

    // Major opcodes handled here
    localparam logic [6:0] OPC_OP_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_OP        = 7'h33;
    localparam logic [6:0] OPC_OP_32     = 7'h3B;
    localparam logic [6:0] OPC_BRANCH    = 7'h63;
    localparam logic [6:0] OPC_JALR      = 7'h67;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Operation carried down the pipe
    typedef enum logic [4:0] {
        K_ADD,
        K_SUB,
        K_SLT,
        K_SLTU,
        K_XOR,
        K_OR,
        K_AND,
        K_SLL,
        K_SRL,
        K_SRA,
        K_BEQ,
        K_BNE,
        K_BLT,
        K_BGE,
        K_BLTU,
        K_BGEU,
        K_JALR
    } kind_t;

endpackage

FILE: rtl/rv64i_integer_execute.sv
// RV64I integer execute: OP-IMM, OP-IMM-32, OP, OP-32, branches and JALR.
// Three-stage pipeline (decode, execute, resolve); uses rvex_pkg.
//
//  channel | dir | word                               | accept
//  s_axis  | in  | insn, pc, rs1_value, rs2_value     | s_axis_tvalid & s_axis_tready
//  m_axis  | out | rd_index .. misaligned, one result | m_axis_tvalid & m_axis_tready
//
// One word per clock sustained while m_axis accepts; a result passes through the
// decode, execute and resolve registers, the last one being the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles close
// up and a stall on m_axis freezes only full stages.
// aresetn (synchronous) clears the stage valid bits; data registers are not reset.
module rv64i_integer_execute
    import rvex_pkg::*;
#(
    parameter int XLEN = XLEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // insn[31:0], pc[95:32], rs1_value[159:96], rs2_value[223:160]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rd_index[4:0], rd_write[5], rd_value[69:6], next_pc[133:70],
    // taken[134], illegal[135], misaligned[136], zero[143:137]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam bit         WIDE      = (XLEN == 64);
    localparam logic [6:0] SHAMT_LIM = 7'(XLEN);
    localparam logic [5:0] SH_MASK   = 6'(XLEN - 1);

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode and operand selection
    // ------------------------------------------------------------------
    logic [INSN_W-1:0] insn;
    logic [XLEN-1:0]   pc_in, a_in, b_in, imm, boff;
    logic [6:0]        opc, f7;
    logic [5:0]        f6, shamt;
    logic [2:0]        f3;

    assign insn  = s_axis_tdata[INSN_W-1:0];
    assign pc_in = s_axis_tdata[32 +: XLEN];
    assign a_in  = s_axis_tdata[96 +: XLEN];
    assign b_in  = s_axis_tdata[160 +: XLEN];
    assign opc   = insn[6:0];
    assign f3    = insn[14:12];
    assign f7    = insn[31:25];
    assign f6    = insn[31:26];
    assign shamt = insn[25:20];
    assign imm   = XLEN'($signed(insn[31:20]));
    assign boff  = XLEN'($signed({insn[31], insn[7], insn[30:25], insn[11:8], 1'b0}));

    kind_t                d_kind;
    logic                 d_word, d_ill;
    logic [XLEN-1:0]      d_opa, d_opb;
    logic [5:0]           d_sh;
    logic [REG_IDX_W-1:0] d_rd;

    always_comb begin
        d_kind = K_ADD;
        d_word = 1'b0;
        d_ill  = 1'b0;
        d_opa  = a_in;
        d_opb  = b_in;
        d_sh   = b_in[5:0] & SH_MASK;
        d_rd   = insn[11:7];
        unique case (opc)
            OPC_OP_IMM: begin
                d_opb = imm;
                d_sh  = shamt;
                unique case (f3)
                    F3_ADD:  d_kind = K_ADD;
                    F3_SLT:  d_kind = K_SLT;
                    F3_SLTU: d_kind = K_SLTU;
                    F3_XOR:  d_kind = K_XOR;
                    F3_OR:   d_kind = K_OR;
                    F3_AND:  d_kind = K_AND;
                    F3_SLL: begin
                        d_kind = K_SLL;
                        d_ill  = (f6 != 6'd0) || ({1'b0, shamt} >= SHAMT_LIM);
                    end
                    default: begin
                        d_kind = f6[4] ? K_SRA : K_SRL;
                        d_ill  = f6[5] || (f6[3:0] != 4'd0)
                                 || ({1'b0, shamt} >= SHAMT_LIM);
                    end
                endcase
            end
            OPC_OP_IMM_32: begin
                d_word = 1'b1;
                d_opb  = imm;
                d_sh   = shamt;
                unique case (f3)
                    F3_ADD: begin
                        d_kind = K_ADD;
                        d_ill  = !WIDE;
                    end
                    F3_SLL: begin
                        d_kind = K_SLL;
                        d_ill  = !WIDE || (f6 != 6'd0) || shamt[5];
                    end
                    F3_SR: begin
                        d_kind = f6[4] ? K_SRA : K_SRL;
                        d_opa  = f6[4] ? XLEN'($signed(a_in[31:0])) : XLEN'(a_in[31:0]);
                        d_ill  = !WIDE || f6[5] || (f6[3:0] != 4'd0) || shamt[5];
                    end
                    default: d_ill = 1'b1;
                endcase
            end
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_ADD:  d_kind = K_ADD;
                        F3_SLL:  d_kind = K_SLL;
                        F3_SLT:  d_kind = K_SLT;
                        F3_SLTU: d_kind = K_SLTU;
                        F3_XOR:  d_kind = K_XOR;
                        F3_SR:   d_kind = K_SRL;
                        F3_OR:   d_kind = K_OR;
                        default: d_kind = K_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    d_kind = K_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    d_kind = K_SRA;
                end else begin
                    d_ill = 1'b1;
                end
            end
            OPC_OP_32: begin
                d_word = 1'b1;
                d_sh   = {1'b0, b_in[4:0]};
                d_ill  = !WIDE;
                if (f7 == F7_BASE && f3 == F3_ADD) begin
                    d_kind = K_ADD;
                end else if (f7 == F7_BASE && f3 == F3_SLL) begin
                    d_kind = K_SLL;
                end else if (f7 == F7_BASE && f3 == F3_SR) begin
                    d_kind = K_SRL;
                    d_opa  = XLEN'(a_in[31:0]);
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    d_kind = K_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    d_kind = K_SRA;
                    d_opa  = XLEN'($signed(a_in[31:0]));
                end else begin
                    d_ill = 1'b1;
                end
            end
            OPC_BRANCH: begin
                d_rd = '0;
                unique case (f3)
                    F3_BEQ:  d_kind = K_BEQ;
                    F3_BNE:  d_kind = K_BNE;
                    F3_BLT:  d_kind = K_BLT;
                    F3_BGE:  d_kind = K_BGE;
                    F3_BLTU: d_kind = K_BLTU;
                    F3_BGEU: d_kind = K_BGEU;
                    default: d_ill  = 1'b1;
                endcase
            end
            OPC_JALR: begin
                d_kind = K_JALR;
                d_opb  = imm;
                d_ill  = (f3 != F3_ADD);
            end
            default: d_ill = 1'b1;
        endcase
    end

    kind_t                kind1_reg;
    logic                 word1_reg, ill1_reg;
    logic [XLEN-1:0]      opa1_reg, opb1_reg, pc1_reg, boff1_reg;
    logic [5:0]           sh1_reg;
    logic [REG_IDX_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            kind1_reg <= d_kind;
            word1_reg <= d_word;
            ill1_reg  <= d_ill;
            opa1_reg  <= d_opa;
            opb1_reg  <= d_opb;
            pc1_reg   <= pc_in;
            boff1_reg <= boff;
            sh1_reg   <= d_sh;
            rd1_reg   <= d_rd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: adder, comparators, shifter, pc adders
    // ------------------------------------------------------------------
    logic            sub, eq, lts, ltu, e_cond;
    logic [XLEN-1:0] addend, sum, e_res;

    assign sub    = (kind1_reg == K_SUB);
    assign addend = sub ? ~opb1_reg : opb1_reg;
    assign sum    = opa1_reg + addend + XLEN'(sub);
    assign eq     = (opa1_reg == opb1_reg);
    assign lts    = ($signed(opa1_reg) < $signed(opb1_reg));
    assign ltu    = (opa1_reg < opb1_reg);

    always_comb begin
        e_res  = sum;
        e_cond = 1'b0;
        unique case (kind1_reg) inside
            K_ADD, K_SUB: e_res = sum;
            K_SLT:  e_res = XLEN'(lts);
            K_SLTU: e_res = XLEN'(ltu);
            K_XOR:  e_res = opa1_reg ^ opb1_reg;
            K_OR:   e_res = opa1_reg | opb1_reg;
            K_AND:  e_res = opa1_reg & opb1_reg;
            K_SLL:  e_res = opa1_reg << sh1_reg;
            K_SRL:  e_res = opa1_reg >> sh1_reg;
            K_SRA:  e_res = XLEN'($signed(opa1_reg) >>> sh1_reg);
            K_BEQ:  e_cond = eq;
            K_BNE:  e_cond = !eq;
            K_BLT:  e_cond = lts;
            K_BGE:  e_cond = !lts;
            K_BLTU: e_cond = ltu;
            K_BGEU: e_cond = !ltu;
            K_JALR: begin
                // target with bit 0 cleared
                e_res  = {sum[XLEN-1:1], 1'b0};
                e_cond = 1'b1;
            end
            default: e_res = sum;
        endcase
    end

    kind_t                kind2_reg;
    logic                 word2_reg, ill2_reg, cond2_reg;
    logic [XLEN-1:0]      res2_reg, pc2_reg, pc4_2_reg, pcbr2_reg;
    logic [REG_IDX_W-1:0] rd2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            kind2_reg <= kind1_reg;
            word2_reg <= word1_reg;
            ill2_reg  <= ill1_reg;
            cond2_reg <= e_cond;
            res2_reg  <= e_res;
            pc2_reg   <= pc1_reg;
            pc4_2_reg <= pc1_reg + XLEN'(4);
            pcbr2_reg <= pc1_reg + boff1_reg;
            rd2_reg   <= rd1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: result select, word sign extension, fault masking
    // ------------------------------------------------------------------
    logic                 is_br, is_jalr, r_mis, r_fault, r_wr, r_tk;
    logic [XLEN-1:0]      r_val, r_npc;
    logic [REG_IDX_W-1:0] r_rd;

    assign is_br   = kind2_reg inside {K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU};
    assign is_jalr = (kind2_reg == K_JALR);
    assign r_mis   = is_jalr && res2_reg[1] && !ill2_reg;
    assign r_fault = ill2_reg || r_mis;

    always_comb begin
        if (r_fault || is_br) begin
            r_val = '0;
        end else if (is_jalr) begin
            r_val = pc4_2_reg;
        end else if (word2_reg) begin
            r_val = XLEN'($signed(res2_reg[31:0]));
        end else begin
            r_val = res2_reg;
        end

        if (r_fault) begin
            r_npc = pc2_reg;
        end else if (is_br) begin
            r_npc = cond2_reg ? pcbr2_reg : pc4_2_reg;
        end else if (is_jalr) begin
            r_npc = res2_reg;
        end else begin
            r_npc = pc4_2_reg;
        end
    end

    assign r_rd = (r_fault || is_br) ? '0 : rd2_reg;
    assign r_wr = !r_fault && !is_br && (rd2_reg != '0);
    assign r_tk = cond2_reg && !r_fault;

    logic [REG_IDX_W-1:0] rd3_reg;
    logic                 wr3_reg, tk3_reg, ill3_reg, mis3_reg;
    logic [XLEN-1:0]      val3_reg, npc3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            rd3_reg  <= r_rd;
            wr3_reg  <= r_wr;
            val3_reg <= r_val;
            npc3_reg <= r_npc;
            tk3_reg  <= r_tk;
            ill3_reg <= ill2_reg;
            mis3_reg <= r_mis;
        end
    end

    // Output word packing
    assign m_axis_tdata = {
        7'd0,
        mis3_reg,
        ill3_reg,
        tk3_reg,
        DATA_W'(npc3_reg),
        DATA_W'(val3_reg),
        wr3_reg,
        rd3_reg
    };

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a fault never writes back or redirects
    a_fault_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && (ill3_reg || mis3_reg) |-> !wr3_reg && !tk3_reg && rd3_reg == '0)
        else $error("fault word has side effects");

    // x0 is never written
    a_no_x0: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && wr3_reg |-> rd3_reg != '0)
        else $error("write to x0");

    // input only back-pressured when every stage is full
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> v1_reg && v2_reg && v3_reg)
        else $error("stall with a free stage");

    // a stalled middle stage keeps its word
    a_hold_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !rdy2 |=> v2_reg && $stable(res2_reg) && $stable(kind2_reg))
        else $error("stage 2 lost its word");

    // illegal and misaligned are exclusive
    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !(ill3_reg && mis3_reg))
        else $error("illegal and misaligned together");

endmodule
